// ----- rtl/core/wpca_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wpca_pkg - waterfall palette colour adjust shared definitions
// Register indexes, field widths, the gain divider request and response
// structs, and the blue-to-red ramp used for the base colour.
// ----------------------------------------------------------------------------
package wpca_pkg;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BRIGHTNESS = 2'd0;
    localparam t_cfg_idx CFG_CONTRAST   = 2'd1;

    // Datapath widths
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned LEVEL_W = 9;
    localparam int unsigned DIFF_W  = 10;   // ramp + brightness - 128
    localparam int unsigned GAIN_W  = 24;   // unsigned Q8.16
    localparam int unsigned PROD_W  = 35;   // signed gain * difference
    localparam int unsigned Q_FRAC  = 16;

    // Gain divider
    localparam int unsigned NUM_W     = 34;
    localparam int unsigned DEN_W     = 17;
    localparam int unsigned DIV_STEPS = NUM_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [GAIN_W-1:0] GAIN_ONE = 24'd65536;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 24'd8486912;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic                      start;
        logic signed [LEVEL_W-1:0] level;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [GAIN_W-1:0] gain;
    } t_div_rsp;

    // Base colour on the blue, cyan, green, yellow, red ramp
    function automatic t_rgb ramp_rgb(input logic [CHAN_W-1:0] n);
        t_rgb              c;
        logic [CHAN_W-1:0] m;
        logic [9:0]        k;
        c.red   = 8'd0;
        c.green = 8'd0;
        c.blue  = 8'd0;
        m       = 8'd0;
        k       = 10'd0;
        if (n == 8'd255) begin
            c.red = 8'd255;
        end else if (n <= 8'd64) begin
            k       = {n, 2'b00};
            c.green = (k > 10'd255) ? 8'd255 : k[7:0];
            c.blue  = 8'd255;
        end else if (n <= 8'd128) begin
            m       = n - 8'd64;
            k       = {m, 2'b00};
            c.green = 8'd255;
            c.blue  = (k > 10'd255) ? 8'd0 : (8'd255 - k[7:0]);
        end else if (n <= 8'd192) begin
            m       = n - 8'd128;
            k       = {m, 2'b00};
            c.red   = (k > 10'd255) ? 8'd255 : k[7:0];
            c.green = 8'd255;
        end else begin
            m       = n - 8'd192;
            c.red   = 8'd255;
            c.green = 8'd255 - {m[5:0], 2'b00};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/wpca_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wpca_req_if - palette index request channel
// Valid/ready channel carrying one colour index per request.
// ----------------------------------------------------------------------------
interface wpca_req_if import wpca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] color_index;

    modport source (output valid, output color_index, input ready);
    modport sink   (input valid, input color_index, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/wpca_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wpca_rsp_if - adjusted colour response channel
// Valid/ready channel carrying one RGB triple per request.
// ----------------------------------------------------------------------------
interface wpca_rsp_if import wpca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_level;
    logic [CHAN_W-1:0] green_level;
    logic [CHAN_W-1:0] blue_level;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, input ready);
    modport sink   (input valid, input red_level, input green_level,
                    input blue_level, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/wpca_gain_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wpca_gain_div - contrast gain divider
// Radix-2 restoring divider producing the Q8.16 contrast gain
// 259*(255+c)*65536 / (255*(259-c)), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpca_gain_div import wpca_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_div_req,
    output t_div_rsp      o_div_rsp
);

    logic signed [LEVEL_W-1:0] lvl_clamp;
    logic signed [9:0]         lvl_w;
    logic signed [9:0]         sum_w;
    logic signed [10:0]        dif_w;
    logic [LEVEL_W-1:0]        sum_s;
    logic [9:0]                dif_s;
    logic [17:0]               num_hi;
    logic [17:0]               den_w;
    logic [NUM_W-1:0]          num_v;
    logic [DEN_W-1:0]          den_v;

    logic                      r_busy;
    logic [CNT_W-1:0]          r_cnt;
    logic [GAIN_W-1:0]         r_gain;
    logic [DEN_W-1:0]          r_rem;
    logic [NUM_W-1:0]          r_quo;
    logic [DEN_W-1:0]          r_den;

    logic [DEN_W:0]            trial;
    logic [DEN_W:0]            trial_sub;
    logic                      bit_set;
    logic [DEN_W-1:0]          n_rem;
    logic [NUM_W-1:0]          n_quo;

    // Clamp the level and form numerator and divisor
    always_comb begin
        lvl_clamp = (i_div_req.level == 9'sh100) ? -9'sd255 : i_div_req.level;
        lvl_w     = 10'(lvl_clamp);
        sum_w     = 10'sd255 + lvl_w;
        sum_s     = sum_w[LEVEL_W-1:0];
        dif_w     = 11'sd259 - 11'(lvl_clamp);
        dif_s     = dif_w[9:0];
        num_hi    = 18'({sum_s, 8'b0}) + 18'({sum_s, 1'b0}) + 18'(sum_s);
        num_v     = {num_hi, 16'b0};
        den_w     = {dif_s, 8'b0} - 18'(dif_s);
        den_v     = den_w[DEN_W-1:0];
    end

    // One restoring step
    always_comb begin
        trial     = {r_rem, r_quo[NUM_W-1]};
        trial_sub = trial - {1'b0, r_den};
        bit_set   = (trial >= {1'b0, r_den});
        n_rem     = bit_set ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        n_quo     = {r_quo[NUM_W-2:0], bit_set};
    end

    // Sequence the division and hold the finished gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_gain <= GAIN_ONE;
        end else if (i_div_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_gain <= n_quo[GAIN_W-1:0];
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Advance the partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_div_req.start) begin
            r_rem <= '0;
            r_quo <= num_v;
            r_den <= den_v;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_div_rsp.busy = r_busy;
    assign o_div_rsp.gain = r_gain;

    a_gain_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_gain == GAIN_ONE) && !r_busy)
        else $error("gain not unity after reset");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> (r_gain <= GAIN_MAX))
        else $error("gain beyond its range after division");

endmodule
`default_nettype wire

// ----- rtl/core/waterfall_palette_color_adjust.sv -----
`default_nettype none
// Throughput: one request per cycle while the gain divider is idle and the
// response side keeps up; the four stages advance independently on stall.
// A contrast write starts a 34-step gain division; requests are held off from
// that write until the division ends. Reset (synchronous, active low) sets
// brightness 0 and gain 1.0, and empties the pipeline.
// ----------------------------------------------------------------------------
// waterfall_palette_color_adjust - palette mapping with brightness/contrast
// Index to ramp colour, brightness offset, contrast gain about mid-level,
// saturation to 0..255, in a four-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
module waterfall_palette_color_adjust import wpca_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire t_cfg_idx              i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    wpca_req_if.sink                   i_req,
    wpca_rsp_if.source                 o_rsp
);

    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    logic signed [LEVEL_W-1:0] r_bright;

    logic                      ld1, ld2, ld3, ld4;
    logic                      req_acc;

    logic                      r_v1, r_v2, r_v3, r_v4;
    t_rgb                      r_rgb1;
    logic signed [DIFF_W-1:0]  r_d2 [3];
    logic signed [PROD_W-1:0]  r_p3 [3];
    t_rgb                      r_out4;

    logic [CHAN_W-1:0]         s1_ch [3];
    logic signed [DIFF_W-1:0]  n_d [3];
    logic signed [GAIN_W:0]    gain_s;
    logic signed [PROD_W-1:0]  n_p [3];
    logic signed [PROD_W-Q_FRAC-1:0] q3 [3];
    logic signed [PROD_W-Q_FRAC:0]   v3 [3];
    logic [CHAN_W-1:0]         n_out [3];

    // Configuration writes
    assign div_req.start = i_cfg_we && (i_cfg_idx == CFG_CONTRAST);
    assign div_req.level = $signed(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= '0;
        end else if (i_cfg_we && (i_cfg_idx == CFG_BRIGHTNESS)) begin
            r_bright <= $signed(i_cfg_data);
        end
    end

    wpca_gain_div u_gain_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_div_req (div_req),
        .o_div_rsp (div_rsp)
    );

    // Per-stage load enables: a stage takes new data when empty or draining
    assign ld4     = !r_v4 || o_rsp.ready;
    assign ld3     = !r_v3 || ld4;
    assign ld2     = !r_v2 || ld3;
    assign ld1     = !r_v1 || ld2;
    assign i_req.ready = ld1 && !div_rsp.busy && !div_req.start;
    assign req_acc = i_req.valid && i_req.ready;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= req_acc;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
            if (ld4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stage datapath: offset, gain multiply, floor and saturate
    assign s1_ch[0] = r_rgb1.red;
    assign s1_ch[1] = r_rgb1.green;
    assign s1_ch[2] = r_rgb1.blue;
    assign gain_s   = $signed({1'b0, div_rsp.gain});

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_d[c] = $signed({2'b00, s1_ch[c]}) + DIFF_W'(r_bright) - 10'sd128;
            n_p[c] = PROD_W'(gain_s) * PROD_W'(r_d2[c]);
            q3[c]  = r_p3[c][PROD_W-1:Q_FRAC];
            v3[c]  = (PROD_W-Q_FRAC+1)'(q3[c]) + 20'sd128;
            if (v3[c] < 0) begin
                n_out[c] = 8'd0;
            end else if (v3[c] > 20'sd255) begin
                n_out[c] = 8'd255;
            end else begin
                n_out[c] = v3[c][CHAN_W-1:0];
            end
        end
    end

    // Hold stage payloads
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_rgb1 <= ramp_rgb(i_req.color_index);
        end
        if (ld2) begin
            r_d2 <= n_d;
        end
        if (ld3) begin
            r_p3 <= n_p;
        end
        if (ld4) begin
            r_out4.red   <= n_out[0];
            r_out4.green <= n_out[1];
            r_out4.blue  <= n_out[2];
        end
    end

    assign o_rsp.valid       = r_v4;
    assign o_rsp.red_level   = r_out4.red;
    assign o_rsp.green_level = r_out4.green;
    assign o_rsp.blue_level  = r_out4.blue;

    a_no_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> !req_acc)
        else $error("request taken while gain division runs");

    a_div_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> div_rsp.busy)
        else $error("contrast write did not start the divider");

    a_req_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> r_v1)
        else $error("accepted request missing from first stage");

endmodule
`default_nettype wire
